// File: design/rvtc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvtc_pkg
// Shared codes, field widths, types and helpers for the trio rare-variant
// transmission counter.
// ----------------------------------------------------------------------------
package rvtc_pkg;

   // field widths
   localparam int GENO_W  = 2;
   localparam int SCORE_W = 8;
   localparam int TRIO_W  = 7;
   localparam int SUM_W   = 32;
   localparam int STAT_W  = 2;

   // genotype codes
   localparam logic [GENO_W-1:0] GENO_MISSING     = 2'd0;
   localparam logic [GENO_W-1:0] GENO_HOM_OTHER   = 2'd1;
   localparam logic [GENO_W-1:0] GENO_HET         = 2'd2;
   localparam logic [GENO_W-1:0] GENO_HOM_COUNTED = 2'd3;

   // trio status codes
   localparam logic [STAT_W-1:0] STATUS_EMPTY    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_ADDED    = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_CONFLICT = 2'd2;

   // saturation limits
   localparam logic [TRIO_W-1:0] TRIO_CAP = {TRIO_W{1'b1}};
   localparam logic [SUM_W-1:0]  SUM_CAP  = {SUM_W{1'b1}};

   // one marker of one trio as held in the input register
   typedef struct packed {
      logic [GENO_W-1:0] father;
      logic [GENO_W-1:0] mother;
      logic [GENO_W-1:0] child;
      logic              swap;
      logic              last;
   } marker_item_type;

   // genotype classification of one marker
   typedef struct packed {
      logic       informative;
      logic       double_het;
      logic [1:0] trans;
      logic [1:0] untrans;
   } marker_eval_type;

   // one result item
   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic                      done;
      logic [STAT_W-1:0]         status;
      logic [TRIO_W-1:0]         trio_t;
      logic [TRIO_W-1:0]         trio_nt;
      logic [SUM_W-1:0]          total_t;
      logic [SUM_W-1:0]          total_nt;
      logic [SUM_W-1:0]          info_total;
   } result_type;

   // flipped marker: homozygous codes trade places
   function automatic logic [GENO_W-1:0] swap_code(input logic [GENO_W-1:0] g,
                                                    input logic swap);
      logic [GENO_W-1:0] r;
      r = g;
      if (swap && (g == GENO_HOM_OTHER || g == GENO_HOM_COUNTED)) begin
         r = g ^ 2'b10;
      end
      return r;
   endfunction

   // parent passes the counted allele to the child
   function automatic logic transmits(input logic [GENO_W-1:0] p,
                                      input logic [GENO_W-1:0] c);
      return (p == GENO_HET && c == GENO_HOM_COUNTED) ||
             (p == GENO_HOM_OTHER && c == GENO_HET);
   endfunction

   // parent keeps the counted allele back
   function automatic logic not_transmits(input logic [GENO_W-1:0] p,
                                          input logic [GENO_W-1:0] c);
      return (c == GENO_HET && p == GENO_HOM_COUNTED) ||
             (c == GENO_HOM_OTHER && p == GENO_HET);
   endfunction

endpackage
`default_nettype wire

// File: design/rvtc_marker_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvtc_marker_eval
// Classifies one marker: allele swap, informativeness, double heterozygosity
// and the number of transmitted and untransmitted parental alleles.
// ----------------------------------------------------------------------------
module rvtc_marker_eval (
   input  wire rvtc_pkg::marker_item_type item,
   output rvtc_pkg::marker_eval_type      eval
);

   logic [rvtc_pkg::GENO_W-1:0] f;
   logic [rvtc_pkg::GENO_W-1:0] m;
   logic [rvtc_pkg::GENO_W-1:0] c;

   // undo the allele flip
   assign f = rvtc_pkg::swap_code(item.father, item.swap);
   assign m = rvtc_pkg::swap_code(item.mother, item.swap);
   assign c = rvtc_pkg::swap_code(item.child, item.swap);

   // informative: child called and one heterozygous parent with a called mate
   always_comb begin
      eval.informative = (c != rvtc_pkg::GENO_MISSING) &&
         ((f == rvtc_pkg::GENO_HET && m != rvtc_pkg::GENO_MISSING) ||
          (m == rvtc_pkg::GENO_HET && f != rvtc_pkg::GENO_MISSING));
      eval.double_het  = (f == rvtc_pkg::GENO_HET) && (m == rvtc_pkg::GENO_HET) &&
                         (c == rvtc_pkg::GENO_HET);
      eval.trans   = {1'b0, rvtc_pkg::transmits(f, c)} +
                     {1'b0, rvtc_pkg::transmits(m, c)};
      eval.untrans = {1'b0, rvtc_pkg::not_transmits(f, c)} +
                     {1'b0, rvtc_pkg::not_transmits(m, c)};
   end

endmodule
`default_nettype wire

// File: design/rvtc_trio_tally.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvtc_trio_tally
// Per-trio counts and conflict flag, saturating running totals, and the
// result of the marker now being processed.
// ----------------------------------------------------------------------------
module rvtc_trio_tally (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           step,
   input  wire                           last,
   input  wire rvtc_pkg::marker_eval_type eval,
   output rvtc_pkg::result_type           result
);

   logic [rvtc_pkg::TRIO_W-1:0] trio_t_ff,  trio_t_in;
   logic [rvtc_pkg::TRIO_W-1:0] trio_nt_ff, trio_nt_in;
   logic                        conflict_ff, conflict_in;
   logic [rvtc_pkg::SUM_W-1:0]  sum_t_ff,  sum_t_in;
   logic [rvtc_pkg::SUM_W-1:0]  sum_nt_ff, sum_nt_in;
   logic [rvtc_pkg::SUM_W-1:0]  info_ff,   info_in;

   logic                        info;
   logic                        dh;
   logic                        record;
   logic                        first;
   logic [rvtc_pkg::TRIO_W-1:0] t1, nt1, t2, nt2;
   logic                        conflict2;
   logic                        close_add;
   logic [1:0]                  info_inc;
   logic [rvtc_pkg::SUM_W:0]    info_sum;
   logic [rvtc_pkg::SUM_W:0]    t_sum;
   logic [rvtc_pkg::SUM_W:0]    nt_sum;

   // marker update of the open trio
   always_comb begin
      info = eval.informative && !conflict_ff;
      dh   = info && eval.double_het;
      t1   = trio_t_ff;
      nt1  = trio_nt_ff;
      if (dh) begin
         t1  = (trio_t_ff == rvtc_pkg::TRIO_CAP)  ? rvtc_pkg::TRIO_CAP  :
               trio_t_ff + 7'd1;
         nt1 = (trio_nt_ff == rvtc_pkg::TRIO_CAP) ? rvtc_pkg::TRIO_CAP :
               trio_nt_ff + 7'd1;
      end
      record    = info && (eval.trans != 2'd0 || eval.untrans != 2'd0);
      first     = (t1 == '0) && (nt1 == '0);
      t2        = (record && first) ? {5'd0, eval.trans}   : t1;
      nt2       = (record && first) ? {5'd0, eval.untrans} : nt1;
      conflict2 = conflict_ff ||
                  (record && !first &&
                   (t1 != {5'd0, eval.trans} || nt1 != {5'd0, eval.untrans}));
   end

   // trio close and saturating totals
   always_comb begin
      close_add = last && !conflict2 && (t2 != '0 || nt2 != '0);
      info_inc  = {1'b0, dh} + {1'b0, close_add};
      info_sum  = {1'b0, info_ff} + {31'd0, info_inc};
      t_sum     = {1'b0, sum_t_ff}  + {26'd0, t2};
      nt_sum    = {1'b0, sum_nt_ff} + {26'd0, nt2};
      info_in   = info_sum[rvtc_pkg::SUM_W] ? rvtc_pkg::SUM_CAP :
                  info_sum[rvtc_pkg::SUM_W-1:0];
      sum_t_in  = sum_t_ff;
      sum_nt_in = sum_nt_ff;
      if (close_add) begin
         sum_t_in  = t_sum[rvtc_pkg::SUM_W]  ? rvtc_pkg::SUM_CAP :
                     t_sum[rvtc_pkg::SUM_W-1:0];
         sum_nt_in = nt_sum[rvtc_pkg::SUM_W] ? rvtc_pkg::SUM_CAP :
                     nt_sum[rvtc_pkg::SUM_W-1:0];
      end
      trio_t_in   = last ? '0 : t2;
      trio_nt_in  = last ? '0 : nt2;
      conflict_in = last ? 1'b0 : conflict2;
   end

   // result fields
   always_comb begin
      result.score = '0;
      if (record && !(conflict2 && !conflict_ff)) begin
         result.score = $signed({6'd0, eval.trans}) - $signed({6'd0, eval.untrans});
      end
      result.done = last;
      priority if (!last) begin
         result.status = rvtc_pkg::STATUS_EMPTY;
      end else if (conflict2) begin
         result.status = rvtc_pkg::STATUS_CONFLICT;
      end else if (close_add) begin
         result.status = rvtc_pkg::STATUS_ADDED;
      end else begin
         result.status = rvtc_pkg::STATUS_EMPTY;
      end
      result.trio_t     = close_add ? t2  : '0;
      result.trio_nt    = close_add ? nt2 : '0;
      result.total_t    = sum_t_in;
      result.total_nt   = sum_nt_in;
      result.info_total = info_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         trio_t_ff   <= '0;
         trio_nt_ff  <= '0;
         conflict_ff <= 1'b0;
         sum_t_ff    <= '0;
         sum_nt_ff   <= '0;
         info_ff     <= '0;
      end else if (step) begin
         trio_t_ff   <= trio_t_in;
         trio_nt_ff  <= trio_nt_in;
         conflict_ff <= conflict_in;
         sum_t_ff    <= sum_t_in;
         sum_nt_ff   <= sum_nt_in;
         info_ff     <= info_in;
      end
   end

endmodule
`default_nettype wire

// File: design/trio_rare_variant_transmission_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trio_rare_variant_transmission_counter
// Collapsed rare-variant transmission counting over parent/child trios.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one rare marker of one trio per transfer, markers of a trio
//   in order; req_tlast flags the final marker and closes the trio.
//   rsp_* returns exactly one result per input transfer, in order: the marker
//   score, on a closing marker the trio status and counts (rsp_tlast high),
//   and the running saturating totals after that marker.
// Timing:
//   the marker is captured in the input register, then passes the genotype
//   logic into the result register once that register is empty or its result
//   is being taken; result valid rises when the result register is written.
//   throughput is one marker per cycle while rsp_tready is high.
// Reset:
//   synchronous reset empties both registers, clears the open trio and all
//   running totals.
// Stalls:
//   when rsp_tready is low the result holds; one more marker waits in the
//   input register, after which req_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module trio_rare_variant_transmission_counter (
   input  wire         clock,
   input  wire         reset,
   // slave side
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [7:0]   req_tdata,  // father_genotype, mother_genotype, child_genotype, pad
   input  wire         req_tuser,  // swap_alleles
   input  wire         req_tlast,  // last_marker
   // master side
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [119:0] rsp_tdata, // marker_score, trio_transmitted, trio_untransmitted,
                                   // total_transmitted, total_untransmitted,
                                   // informative_total, pad
   output logic [1:0]  rsp_tuser,  // trio_status
   output logic        rsp_tlast   // trio_done
);

   logic                      in_valid_ff, in_valid_in;
   rvtc_pkg::marker_item_type in_item_ff;
   logic                      out_valid_ff, out_valid_in;
   rvtc_pkg::result_type      out_ff;
   logic                      advance;
   rvtc_pkg::marker_eval_type eval;
   rvtc_pkg::result_type      result;

   // pipeline control
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.father <= req_tdata[1:0];
         in_item_ff.mother <= req_tdata[3:2];
         in_item_ff.child  <= req_tdata[5:4];
         in_item_ff.swap   <= req_tuser;
         in_item_ff.last   <= req_tlast;
      end
   end

   rvtc_marker_eval u_eval (
      .item (in_item_ff),
      .eval (eval)
   );

   rvtc_trio_tally u_tally (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .last   (in_item_ff.last),
      .eval   (eval),
      .result (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   // output packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.done;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {2'b00, out_ff.info_total, out_ff.total_nt, out_ff.total_t,
                        out_ff.trio_nt, out_ff.trio_t, out_ff.score};

endmodule
`default_nettype wire
